// ===== sv/isodur_pkg.sv =====
// types, constants and the power-of-ten table for the iso8601 duration parser
// used by isodur_alu, isodur_ctrl and the top level; depends on nothing
`default_nettype none

package isodur_pkg;

	localparam int CharW   = 8;
	localparam int MantW   = 60;
	localparam int UnitW   = 25;
	localparam int ProdW   = MantW + UnitW;
	localparam int TotalW  = 63;
	localparam int StatusW = 3;
	localparam int FracIdxW = 5;
	localparam int StepW   = $clog2(ProdW);

	localparam logic [CharW-1:0] ChP   = 8'h50;
	localparam logic [CharW-1:0] ChT   = 8'h54;
	localparam logic [CharW-1:0] ChY   = 8'h59;
	localparam logic [CharW-1:0] ChH   = 8'h48;
	localparam logic [CharW-1:0] ChM   = 8'h4D;
	localparam logic [CharW-1:0] ChS   = 8'h53;
	localparam logic [CharW-1:0] ChDot = 8'h2E;
	localparam logic [CharW-1:0] Ch0   = 8'h30;
	localparam logic [CharW-1:0] Ch9   = 8'h39;

	localparam logic [UnitW-1:0] SecPerYear = 25'd31536000;
	localparam logic [UnitW-1:0] SecPerHour = 25'd3600;
	localparam logic [UnitW-1:0] SecPerMin  = 25'd60;
	localparam logic [UnitW-1:0] SecPerSec  = 25'd1;

	localparam logic [ProdW-1:0] TermLimit  = ProdW'(32'h7FFF_FFFF);
	localparam logic [ProdW-1:0] TotalLimit = ProdW'(63'h7FFF_FFFF_FFFF_FFFF);

	typedef enum logic [StatusW-1:0] {
		ST_OK       = 3'd0,
		ST_NO_P     = 3'd1,
		ST_BAD_UNIT = 3'd2,
		ST_DATES    = 3'd3,
		ST_OVERFLOW = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		PH_EXPECT_P,
		PH_AFTER_P,
		PH_YEARS,
		PH_TIMES
	} phase_t;

	typedef enum logic [2:0] {
		SQ_IDLE,
		SQ_MUL,
		SQ_DIV,
		SQ_ADD,
		SQ_DONE
	} seq_t;

	typedef enum logic [1:0] {
		ALU_NOP,
		ALU_LOAD,
		ALU_MUL_STEP,
		ALU_DIV_STEP
	} alu_op_t;

	typedef struct packed {
		alu_op_t          op;
		logic [MantW-1:0] mcand;
		logic [UnitW-1:0] unit;
		logic [MantW-1:0] divisor;
	} alu_ctl_t;

	function automatic logic [MantW-1:0] pow10(input logic [FracIdxW-1:0] n);
		logic [MantW-1:0] r;
		case (n)
			5'd0:  r = 60'd1;
			5'd1:  r = 60'd10;
			5'd2:  r = 60'd100;
			5'd3:  r = 60'd1000;
			5'd4:  r = 60'd10000;
			5'd5:  r = 60'd100000;
			5'd6:  r = 60'd1000000;
			5'd7:  r = 60'd10000000;
			5'd8:  r = 60'd100000000;
			5'd9:  r = 60'd1000000000;
			5'd10: r = 60'd10000000000;
			5'd11: r = 60'd100000000000;
			5'd12: r = 60'd1000000000000;
			5'd13: r = 60'd10000000000000;
			5'd14: r = 60'd100000000000000;
			5'd15: r = 60'd1000000000000000;
			5'd16: r = 60'd10000000000000000;
			5'd17: r = 60'd100000000000000000;
			5'd18: r = 60'd1000000000000000000;
			default: r = 60'd1;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== sv/iso8601_duration_to_seconds.sv =====
// top level of the iso8601 duration to seconds converter
// depends on isodur_pkg, isodur_alu and isodur_ctrl
//
// input channel: one character per transaction (char_code, is_last), taken
// when in_valid is high and in_stall is low. the string must start with P,
// then either year terms (nY) or T and any mix of H, M and S terms; numbers
// may carry a fraction after a dot.
// output channel: one transaction (total_seconds, status) per string, on the
// character flagged is_last; total_seconds is 0 whenever status is not ok.
// sequencing: a digit, dot, P or T is taken in the idle state. a unit letter runs the shared
// unit: 25 shift-add multiply steps, then 85 restoring divide steps when the
// number has a fraction, then an add step. the final character then passes
// through a done state that loads the result register.
// in_stall is high while the shared unit is busy and while a finished result
// waits for a free output register. the output register holds its value
// while out_stall is high, and the parser keeps accepting characters of the
// next string until that string's final result needs the register.
// reset clears the parser to expect a leading P and drops out_valid.
`default_nettype none

module iso8601_duration_to_seconds
	import isodur_pkg::*;
#(
	parameter int MAX_DIGITS = 18
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic [CharW-1:0]  char_code,
	input  wire logic              is_last,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic [TotalW-1:0]      total_seconds,
	output logic [StatusW-1:0]     status
);

	alu_ctl_t          alu_ctl;
	logic [ProdW-1:0]  alu_res;

	isodur_ctrl #(
		.MAX_DIGITS(MAX_DIGITS)
	) u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.char_code     (char_code),
		.is_last       (is_last),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.total_seconds (total_seconds),
		.status        (status),
		.alu_ctl       (alu_ctl),
		.alu_res       (alu_res)
	);

	isodur_alu u_alu (
		.clk    (clk),
		.ctl    (alu_ctl),
		.result (alu_res)
	);

endmodule

`default_nettype wire

// ===== sv/isodur_alu.sv =====
// shared arithmetic unit: shift-add multiply, then restoring divide by a power of ten
// depends on isodur_pkg
`default_nettype none

module isodur_alu
	import isodur_pkg::*;
(
	input  wire logic             clk,
	input  wire alu_ctl_t         ctl,
	output logic [ProdW-1:0]      result
);

	logic [ProdW-1:0] acc_q;
	logic [MantW-1:0] mcand_q;
	logic [UnitW-1:0] mplier_q;
	logic [MantW-1:0] div_q;
	logic [MantW-1:0] rem_q;

	logic [MantW:0]   trial;
	logic [MantW:0]   diff;
	logic             take;
	logic [ProdW-1:0] addend;

	// acc_q holds the product, then shifts into the quotient during division
	assign trial  = {rem_q, acc_q[ProdW-1]};
	assign diff   = trial - {1'b0, div_q};
	assign take   = (trial >= {1'b0, div_q});
	assign addend = mplier_q[UnitW-1] ? ProdW'(mcand_q) : '0;

	always_ff @(posedge clk) begin
		case (ctl.op)
			ALU_LOAD: begin
				acc_q    <= '0;
				rem_q    <= '0;
				mcand_q  <= ctl.mcand;
				mplier_q <= ctl.unit;
				div_q    <= ctl.divisor;
			end
			ALU_MUL_STEP: begin
				acc_q    <= {acc_q[ProdW-2:0], 1'b0} + addend;
				mplier_q <= {mplier_q[UnitW-2:0], 1'b0};
			end
			ALU_DIV_STEP: begin
				acc_q <= {acc_q[ProdW-2:0], take};
				rem_q <= take ? diff[MantW-1:0] : trial[MantW-1:0];
			end
			default: begin
			end
		endcase
	end

	assign result = acc_q;

endmodule

`default_nettype wire

// ===== sv/isodur_ctrl.sv =====
// character parser, sequencer for the shared unit, and result register
// depends on isodur_pkg; drives isodur_alu through an alu_ctl_t struct
`default_nettype none

module isodur_ctrl
	import isodur_pkg::*;
#(
	parameter int MAX_DIGITS = 18
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic [CharW-1:0]  char_code,
	input  wire logic              is_last,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic [TotalW-1:0]      total_seconds,
	output logic [StatusW-1:0]     status,
	output alu_ctl_t               alu_ctl,
	input  wire logic [ProdW-1:0]  alu_res
);

	localparam int CntW = $clog2(MAX_DIGITS + 1);
	localparam logic [CntW-1:0]  DigitMax = CntW'(MAX_DIGITS);
	localparam logic [StepW-1:0] MulLast  = StepW'(UnitW - 1);
	localparam logic [StepW-1:0] DivLast  = StepW'(ProdW - 1);

	seq_t              seq_q, seq_d;
	phase_t            phase_q;
	status_t           err_q;
	logic [MantW-1:0]  mant_q;
	logic [CntW-1:0]   frac_q;
	logic              in_frac_q;
	logic [CntW-1:0]   dcnt_q;
	logic [TotalW-1:0] run_q;
	logic              last_q;
	logic              year_q;
	logic [StepW-1:0]  step_q;
	logic              out_valid_q;
	logic [TotalW-1:0] tot_q;
	status_t           stat_q;

	// parser decode of the incoming character
	phase_t            p_phase;
	status_t           p_err;
	logic [MantW-1:0]  p_mant;
	logic [CntW-1:0]   p_frac;
	logic              p_in_frac;
	logic [CntW-1:0]   p_dcnt;
	logic              ch_start;
	logic              ch_year;
	logic [UnitW-1:0]  ch_unit;
	logic              yr, tm;
	logic              is_digit;

	logic              accept;
	logic              slot_free;
	logic              term_ovf;
	logic [TotalW:0]   sum;
	status_t           fin_err;

	assign accept    = in_valid && (seq_q == SQ_IDLE);
	assign slot_free = !out_valid_q || !out_stall;
	assign is_digit  = (char_code >= Ch0) && (char_code <= Ch9);

	always_comb begin
		p_phase   = phase_q;
		p_err     = err_q;
		p_mant    = mant_q;
		p_frac    = frac_q;
		p_in_frac = in_frac_q;
		p_dcnt    = dcnt_q;
		ch_start  = 1'b0;
		ch_year   = 1'b0;
		ch_unit   = SecPerSec;
		yr        = 1'b0;
		tm        = 1'b0;
		if (err_q == ST_OK) begin
			case (phase_q)
				PH_EXPECT_P: begin
					if (char_code == ChP) p_phase = PH_AFTER_P;
					else p_err = ST_NO_P;
				end
				PH_AFTER_P: begin
					if (char_code == ChT) begin
						p_phase = PH_TIMES;
					end else begin
						p_phase = PH_YEARS;
						yr = 1'b1;
					end
				end
				PH_YEARS: yr = 1'b1;
				PH_TIMES: tm = 1'b1;
				default: p_err = ST_BAD_UNIT;
			endcase
		end
		if (yr || tm) begin
			if (is_digit) begin
				if (dcnt_q >= DigitMax) begin
					p_err = ST_OVERFLOW;
				end else begin
					// low nibble of an ascii digit is its value
					p_mant = {mant_q[MantW-4:0], 3'b000} + {mant_q[MantW-2:0], 1'b0}
						+ MantW'(char_code[3:0]);
					p_dcnt = dcnt_q + 1'b1;
					if (in_frac_q) p_frac = frac_q + 1'b1;
				end
			end else if (char_code == ChDot) begin
				if (in_frac_q) p_err = ST_BAD_UNIT;
				else p_in_frac = 1'b1;
			end else if (yr && char_code == ChY) begin
				ch_start = 1'b1;
				ch_year  = 1'b1;
				ch_unit  = SecPerYear;
			end else if (tm && char_code == ChH) begin
				ch_start = 1'b1;
				ch_unit  = SecPerHour;
			end else if (tm && char_code == ChM) begin
				ch_start = 1'b1;
				ch_unit  = SecPerMin;
			end else if (tm && char_code == ChS) begin
				ch_start = 1'b1;
				ch_unit  = SecPerSec;
			end else begin
				p_err = ST_BAD_UNIT;
			end
		end
	end

	// term check and running total update
	assign term_ovf = year_q ? (alu_res > TotalLimit) : (alu_res > TermLimit);
	assign sum      = {1'b0, run_q} + {1'b0, alu_res[TotalW-1:0]};

	// end-of-string status
	always_comb begin
		fin_err = err_q;
		if (err_q == ST_OK) begin
			if (phase_q == PH_AFTER_P || phase_q == PH_EXPECT_P) fin_err = ST_DATES;
			else if (dcnt_q != '0 || in_frac_q) fin_err = ST_BAD_UNIT;
			else if (phase_q == PH_YEARS && run_q == '0) fin_err = ST_DATES;
		end
	end

	// next state
	always_comb begin
		seq_d = seq_q;
		case (seq_q)
			SQ_IDLE: begin
				if (in_valid) begin
					if (ch_start) seq_d = SQ_MUL;
					else if (is_last) seq_d = SQ_DONE;
				end
			end
			SQ_MUL: begin
				if (step_q == MulLast) seq_d = (frac_q == '0) ? SQ_ADD : SQ_DIV;
			end
			SQ_DIV: begin
				if (step_q == DivLast) seq_d = SQ_ADD;
			end
			SQ_ADD:  seq_d = last_q ? SQ_DONE : SQ_IDLE;
			SQ_DONE: if (slot_free) seq_d = SQ_IDLE;
			default: seq_d = SQ_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		in_stall        = (seq_q != SQ_IDLE);
		alu_ctl.op      = ALU_NOP;
		alu_ctl.mcand   = mant_q;
		alu_ctl.unit    = ch_unit;
		alu_ctl.divisor = pow10(FracIdxW'(frac_q));
		case (seq_q)
			SQ_IDLE: if (in_valid && ch_start) alu_ctl.op = ALU_LOAD;
			SQ_MUL:  alu_ctl.op = ALU_MUL_STEP;
			SQ_DIV:  alu_ctl.op = ALU_DIV_STEP;
			default: alu_ctl.op = ALU_NOP;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q       <= SQ_IDLE;
			phase_q     <= PH_EXPECT_P;
			err_q       <= ST_OK;
			mant_q      <= '0;
			frac_q      <= '0;
			in_frac_q   <= 1'b0;
			dcnt_q      <= '0;
			run_q       <= '0;
			last_q      <= 1'b0;
			year_q      <= 1'b0;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			seq_q <= seq_d;
			if (seq_q == SQ_DONE && slot_free) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
			case (seq_q)
				SQ_IDLE: begin
					if (accept) begin
						phase_q   <= p_phase;
						err_q     <= p_err;
						mant_q    <= p_mant;
						frac_q    <= p_frac;
						in_frac_q <= p_in_frac;
						dcnt_q    <= p_dcnt;
						last_q    <= is_last;
						year_q    <= ch_year;
						step_q    <= '0;
					end
				end
				SQ_MUL: begin
					if (step_q == MulLast) step_q <= '0;
					else step_q <= step_q + 1'b1;
				end
				SQ_DIV: step_q <= step_q + 1'b1;
				SQ_ADD: begin
					if (term_ovf || sum[TotalW]) begin
						err_q <= ST_OVERFLOW;
					end else begin
						run_q     <= sum[TotalW-1:0];
						mant_q    <= '0;
						frac_q    <= '0;
						in_frac_q <= 1'b0;
						dcnt_q    <= '0;
					end
				end
				SQ_DONE: begin
					if (slot_free) begin
						phase_q     <= PH_EXPECT_P;
						err_q       <= ST_OK;
						mant_q      <= '0;
						frac_q      <= '0;
						in_frac_q   <= 1'b0;
						dcnt_q      <= '0;
						run_q       <= '0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (seq_q == SQ_DONE && slot_free) begin
			tot_q  <= (fin_err == ST_OK) ? run_q : '0;
			stat_q <= fin_err;
		end
	end

	assign out_valid     = out_valid_q;
	assign total_seconds = tot_q;
	assign status        = stat_q;

`ifndef NO_ASSERTIONS
	a_err_zero_total: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && stat_q != ST_OK |-> tot_q == '0)
		else $error("error result carries a nonzero total");

	a_mul_exit: assert property (@(posedge clk) disable iff (!arst_n)
		seq_q == SQ_MUL |=> seq_q == SQ_MUL || seq_q == SQ_DIV || seq_q == SQ_ADD)
		else $error("multiply left to an unexpected state");

	a_div_hold: assert property (@(posedge clk) disable iff (!arst_n)
		seq_q == SQ_DIV && step_q != DivLast |=> seq_q == SQ_DIV)
		else $error("divide ended early");

	a_err_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		accept && err_q != ST_OK && !is_last |=> seq_q == SQ_IDLE && $stable(err_q))
		else $error("character after an error was not ignored");

	a_done_emit: assert property (@(posedge clk) disable iff (!arst_n)
		seq_q == SQ_DONE && slot_free |=> out_valid_q && phase_q == PH_EXPECT_P)
		else $error("result not loaded or parser not cleared");
`endif

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
// testbench for iso8601_duration_to_seconds: directed and random duration strings,
// checked result by result against an in-bench parser with exact integer scaling
// depends on isodur_pkg and the iso8601_duration_to_seconds rtl
module tb;
	import isodur_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int MaxDigits = 18;
	localparam int CycleLimit = 1_000_000;
	localparam int RandomChars = 925;
	localparam int TailCycles = 150;
	localparam logic [63:0] UnitYear = 64'd31536000;
	localparam logic [63:0] UnitHour = 64'd3600;
	localparam logic [63:0] UnitMin = 64'd60;
	localparam logic [63:0] UnitSec = 64'd1;
	localparam logic [63:0] TimeTermMax = 64'h0000_0000_7FFF_FFFF;
	localparam logic [63:0] TotalMax = 64'h7FFF_FFFF_FFFF_FFFF;

	typedef struct {
		logic [CharW-1:0] ch;
		bit last;
		bit drain;
	} char_item_t;

	typedef struct {
		logic [TotalW-1:0] secs;
		status_t st;
	} duration_t;

	logic clk;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic [CharW-1:0] char_code = '0;
	logic is_last = 1'b0;
	logic out_stall = 1'b0;
	logic in_stall;
	logic out_valid;
	logic [TotalW-1:0] total_seconds;
	logic [StatusW-1:0] status;

	char_item_t char_queue[$];
	char_item_t next_char;
	logic [CharW-1:0] text_buf[$];
	duration_t pending_durations[$];
	duration_t oldest;

	// running state of the in-bench parser
	phase_t cur_phase;
	logic [MantW-1:0] term_mant;
	int unsigned term_frac;
	bit term_in_frac;
	int unsigned term_digits;
	logic [63:0] secs_so_far;
	status_t first_error;

	bit char_taken = 1'b0;
	int chars_accepted = 0;
	int results_seen = 0;
	int parsed_ok = 0;
	int mismatches = 0;
	int strings_queued = 0;
	int cycle_count = 0;
	int hold_left = 0;
	bit hold_done = 1'b0;
	wire quiet_stretch = chars_accepted >= 400 && chars_accepted < 700;

	iso8601_duration_to_seconds i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.char_code(char_code),
		.is_last(is_last),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.total_seconds(total_seconds),
		.status(status)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	task automatic clear_term();
		term_mant = '0;
		term_frac = 0;
		term_in_frac = 1'b0;
		term_digits = 0;
	endtask

	task automatic restart_parser();
		cur_phase = PH_EXPECT_P;
		clear_term();
		secs_so_far = '0;
		first_error = ST_OK;
	endtask

	// floor(mantissa * unit / 10^frac), one truncating divide per fraction digit
	task automatic add_term(input logic [63:0] unit, input logic [63:0] limit);
		logic [127:0] scaled;
		logic [63:0] sum;
		int i;
		scaled = 128'(term_mant) * 128'(unit);
		for (i = 0; i < term_frac; i++)
			scaled = scaled / 10;
		if (scaled > 128'(limit)) begin
			first_error = ST_OVERFLOW;
		end else begin
			sum = secs_so_far + scaled[63:0];
			if (sum > TotalMax) begin
				first_error = ST_OVERFLOW;
			end else begin
				secs_so_far = sum;
				clear_term();
			end
		end
	endtask

	task automatic term_char(input logic [CharW-1:0] c);
		if (c >= Ch0 && c <= Ch9) begin
			if (term_digits >= MaxDigits) begin
				first_error = ST_OVERFLOW;
			end else begin
				term_mant = term_mant * 10 + MantW'(c - Ch0);
				term_digits++;
				if (term_in_frac)
					term_frac++;
			end
		end else if (c == ChDot) begin
			if (term_in_frac)
				first_error = ST_BAD_UNIT;
			else
				term_in_frac = 1'b1;
		end else if (cur_phase == PH_YEARS && c == ChY) begin
			add_term(UnitYear, TotalMax);
		end else if (cur_phase == PH_TIMES && c == ChH) begin
			add_term(UnitHour, TimeTermMax);
		end else if (cur_phase == PH_TIMES && c == ChM) begin
			add_term(UnitMin, TimeTermMax);
		end else if (cur_phase == PH_TIMES && c == ChS) begin
			add_term(UnitSec, TimeTermMax);
		end else begin
			first_error = ST_BAD_UNIT;
		end
	endtask

	task automatic parse_char(input logic [CharW-1:0] c, input bit last);
		duration_t r;
		if (first_error == ST_OK) begin
			case (cur_phase)
				PH_EXPECT_P: begin
					if (c == ChP)
						cur_phase = PH_AFTER_P;
					else
						first_error = ST_NO_P;
				end
				PH_AFTER_P: begin
					if (c == ChT) begin
						cur_phase = PH_TIMES;
					end else begin
						cur_phase = PH_YEARS;
						term_char(c);
					end
				end
				default: term_char(c);
			endcase
		end
		if (last) begin
			if (first_error == ST_OK) begin
				if (cur_phase == PH_EXPECT_P || cur_phase == PH_AFTER_P)
					first_error = ST_DATES;
				else if (term_digits != 0 || term_in_frac)
					first_error = ST_BAD_UNIT;
				else if (cur_phase == PH_YEARS && secs_so_far == 0)
					first_error = ST_DATES;
			end
			r.secs = (first_error == ST_OK) ? secs_so_far[TotalW-1:0] : '0;
			r.st = first_error;
			pending_durations.push_back(r);
			restart_parser();
		end
	endtask

	task automatic add_str(input string s);
		int i;
		for (i = 0; i < s.len(); i++)
			text_buf.push_back(s[i]);
	endtask

	task automatic emit_text(input bit drain);
		char_item_t it;
		int i;
		for (i = 0; i < text_buf.size(); i++) begin
			it.ch = text_buf[i];
			it.last = (i == text_buf.size() - 1);
			it.drain = drain && i == 0;
			char_queue.push_back(it);
		end
		strings_queued++;
		text_buf.delete();
	endtask

	task automatic directed(input string s);
		add_str(s);
		emit_text(1'b0);
	endtask

	// digits with an optional dot; mostly short, now and then long or over the limit
	task automatic add_number();
		int r;
		int ndig;
		int dot_at;
		int i;
		r = $urandom_range(0, 19);
		if (r == 0)
			ndig = 0;
		else if (r < 16)
			ndig = $urandom_range(1, 4);
		else if (r < 19)
			ndig = $urandom_range(5, 18);
		else
			ndig = 19;
		dot_at = ($urandom_range(0, 2) == 0) ? $urandom_range(0, ndig) : -1;
		for (i = 0; i <= ndig; i++) begin
			if (i == dot_at)
				text_buf.push_back(ChDot);
			if (i < ndig)
				text_buf.push_back(Ch0 + CharW'($urandom_range(0, 9)));
		end
	endtask

	task automatic random_string(input bit drain);
		string letters;
		int kind;
		int n;
		int i;
		letters = "0123456789.PTYHMS";
		kind = $urandom_range(0, 99);
		if (kind < 88) begin
			text_buf.push_back(ChP);
			if ($urandom_range(0, 3) == 0) begin
				n = $urandom_range(1, 3);
				for (i = 0; i < n; i++) begin
					add_number();
					text_buf.push_back(ChY);
				end
			end else begin
				text_buf.push_back(ChT);
				n = $urandom_range(0, 4);
				for (i = 0; i < n; i++) begin
					add_number();
					case ($urandom_range(0, 2))
						0: text_buf.push_back(ChH);
						1: text_buf.push_back(ChM);
						default: text_buf.push_back(ChS);
					endcase
				end
			end
			// broken sequence: overwrite one character or cut the tail off
			if (kind >= 72) begin
				i = $urandom_range(0, text_buf.size() - 1);
				if ($urandom_range(0, 1) == 0)
					text_buf[i] = CharW'($urandom_range(0, 255));
				else if (text_buf.size() > 1)
					void'(text_buf.pop_back());
			end
		end else begin
			if ($urandom_range(0, 1) == 0)
				text_buf.push_back(ChP);
			n = $urandom_range(1, 6);
			for (i = 0; i < n; i++) begin
				if ($urandom_range(0, 1) == 0)
					text_buf.push_back(letters[$urandom_range(0, letters.len() - 1)]);
				else
					text_buf.push_back(CharW'($urandom_range(0, 255)));
			end
		end
		emit_text(drain);
	endtask

	// driver: one transaction offered at a time, held while stalled
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (in_valid && !char_taken) begin
		end else if (char_queue.size() == 0) begin
			in_valid <= 1'b0;
		end else if (char_queue[0].drain && pending_durations.size() != 0) begin
			in_valid <= 1'b0;
		end else if (!quiet_stretch && $urandom_range(0, 99) < 32) begin
			in_valid <= 1'b0;
		end else begin
			next_char = char_queue.pop_front();
			in_valid <= 1'b1;
			char_code <= next_char.ch;
			is_last <= next_char.last;
		end
	end

	// receiver stall, with one long hold-off so the block backs up into its input
	always @(negedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else if (hold_left != 0) begin
			out_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (!hold_done && results_seen >= 40) begin
			hold_done <= 1'b1;
			hold_left <= 600;
			out_stall <= 1'b1;
		end else begin
			out_stall <= !quiet_stretch && $urandom_range(0, 99) < 32;
		end
	end

	// monitor: check results, then feed accepted characters to the parser
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				results_seen++;
				if (pending_durations.size() == 0) begin
					mismatches++;
					$display("%0t: result with nothing expected: total %0d status %0d",
						$time, total_seconds, status);
				end else begin
					oldest = pending_durations.pop_front();
					if (oldest.st == ST_OK)
						parsed_ok++;
					if (total_seconds !== oldest.secs) begin
						mismatches++;
						$display("%0t: total_seconds expected %0d actual %0d",
							$time, oldest.secs, total_seconds);
					end
					if (status !== oldest.st) begin
						mismatches++;
						$display("%0t: status expected %0d actual %0d",
							$time, oldest.st, status);
					end
				end
			end
			char_taken = in_valid && !in_stall;
			if (in_valid && !in_stall) begin
				chars_accepted++;
				parse_char(char_code, is_last);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CycleLimit) begin
			$display("%0t: timeout, %0d results still expected", $time,
				pending_durations.size());
			$display("[iso8601_duration_to_seconds] ERROR");
			$finish;
		end
	end

	initial begin
		int random_start;
		int k;
		restart_parser();

		directed("PT");
		directed("P");
		directed("Q");
		directed("XT5S");
		directed("P0Y");
		directed("P1Y");
		directed("P1.5Y2Y");
		directed("PT1H30M15.5S");
		directed("PT.5M");
		directed("PTH");
		directed("PT.S");
		directed("PT5");
		directed("PT1.2.3S");
		directed("P1T");
		directed("PT1Y");
		directed("P12");
		directed("PT59.999999S");
		directed("PT9999999999999999999S");
		directed("PT999999999999999999S");
		directed("PT2147483647S");
		directed("PT2147483648S");
		directed("P999999999999999999Y");
		directed("P200000000000Y200000000000Y");
		directed("P.000000000000000001Y");
		// control byte zero and a top-bit byte in place of a unit
		add_str("PT");
		text_buf.push_back(8'h00);
		add_str("5S");
		emit_text(1'b0);
		add_str("PT1");
		text_buf.push_back(8'hFF);
		add_str("S");
		emit_text(1'b0);

		random_start = char_queue.size();
		k = 0;
		while (char_queue.size() - random_start < RandomChars) begin
			random_string(k % 40 == 0);
			k++;
		end

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (char_queue.size() != 0 || in_valid)
			@(posedge clk);
		while (pending_durations.size() != 0)
			@(posedge clk);
		repeat (TailCycles) @(posedge clk);

		$display("%0d duration strings in %0d characters checked: %0d parsed, %0d rejected",
			results_seen, chars_accepted, parsed_ok, results_seen - parsed_ok);
		if (mismatches == 0)
			$display("[iso8601_duration_to_seconds] OK");
		else
			$display("[iso8601_duration_to_seconds] ERROR");
		$finish;
	end

endmodule

// ===== iso8601_duration_to_seconds.f =====
sv/isodur_pkg.sv
sv/isodur_alu.sv
sv/isodur_ctrl.sv
sv/iso8601_duration_to_seconds.sv
tb/sv/tb.sv
